FILE: rtl/core/bsa_pkg.sv
// bsa_pkg: shared types, widths and opcode constants for the bit-slice alu
// no dependencies

package bsa_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int RF_DEPTH   = 16;
    localparam int RF_AW      = $clog2(RF_DEPTH);

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [RF_AW-1:0]      t_raddr;

    // alu function, opcode bits 5..3
    localparam logic [2:0] FN_ADD   = 3'd0;
    localparam logic [2:0] FN_SUBR  = 3'd1;
    localparam logic [2:0] FN_SUBS  = 3'd2;
    localparam logic [2:0] FN_OR    = 3'd3;
    localparam logic [2:0] FN_AND   = 3'd4;
    localparam logic [2:0] FN_NOTRS = 3'd5;
    localparam logic [2:0] FN_EXOR  = 3'd6;
    localparam logic [2:0] FN_EXNOR = 3'd7;

    // operand pair (r, s), opcode bits 2..0
    localparam logic [2:0] SRC_AQ = 3'd0;
    localparam logic [2:0] SRC_AB = 3'd1;
    localparam logic [2:0] SRC_ZQ = 3'd2;
    localparam logic [2:0] SRC_ZB = 3'd3;
    localparam logic [2:0] SRC_ZA = 3'd4;
    localparam logic [2:0] SRC_DA = 3'd5;
    localparam logic [2:0] SRC_DQ = 3'd6;
    localparam logic [2:0] SRC_DZ = 3'd7;

    // destination control
    localparam logic [2:0] DST_QREG  = 3'd0;
    localparam logic [2:0] DST_NOP   = 3'd1;
    localparam logic [2:0] DST_RAMA  = 3'd2;
    localparam logic [2:0] DST_RAMF  = 3'd3;
    localparam logic [2:0] DST_RAMQD = 3'd4;
    localparam logic [2:0] DST_RAMD  = 3'd5;
    localparam logic [2:0] DST_RAMQU = 3'd6;
    localparam logic [2:0] DST_RAMU  = 3'd7;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [2:0]  destination;
        t_raddr      addr_a;
        t_raddr      addr_b;
        logic        carry_in;
        logic [15:0] direct_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] alu_result;
        logic [15:0] y_out;
    } t_out_item;

    // writeback controls from the alu to the register file and q
    typedef struct packed {
        logic   rf_we;
        t_word  rf_wdata;
        logic   q_we;
        t_word  q_wdata;
    } t_wb;

endpackage

FILE: rtl/core/bsa_if.sv
// bsa_if: valid/ready channel interfaces for command and result beats
// depends on bsa_pkg

interface bsa_in_if;
    import bsa_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsa_out_if;
    import bsa_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/bit_slice_alu_16bit.sv
// bit_slice_alu_16bit: one microinstruction per beat on a 16-bit slice datapath
// path: command beat to result beat through the input register, then the result register
// throughput: one beat per cycle while the result side is not stalled; execute and writeback happen in the same cycle,
// so the next command sees the updated register file and q without stalls
// reset: register file and q read as zero right after reset, no clearing pass
// depends on bsa_pkg, bsa_if, bsa_regfile, bsa_alu

module bit_slice_alu_16bit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsa_in_if.sink    i_cmd,
    bsa_out_if.source o_res
);
    import bsa_pkg::*;

    logic      r_in_vld;
    logic      n_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    logic      n_out_vld;
    t_out_item r_out;
    t_word     r_q;
    logic      accept;
    logic      fire;
    t_word     rf_a;
    t_word     rf_b;
    t_word     f;
    t_word     y;
    t_wb       wb;

    assign fire   = r_in_vld && (!r_out_vld || o_res.ready);
    assign accept = i_cmd.valid && i_cmd.ready;

    assign i_cmd.ready = !r_in_vld || fire;
    assign n_in_vld    = accept || (r_in_vld && !fire);
    assign n_out_vld   = fire || (r_out_vld && !o_res.ready);

    bsa_regfile u_rf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_addr_a (i_cmd.data.addr_a),
        .i_addr_b (i_cmd.data.addr_b),
        .o_data_a (rf_a),
        .o_data_b (rf_b),
        .i_we     (fire && wb.rf_we),
        .i_waddr  (r_in.addr_b),
        .i_wdata  (wb.rf_wdata)
    );

    bsa_alu u_alu (
        .i_item (r_in),
        .i_a    (rf_a),
        .i_b    (rf_b),
        .i_q    (r_q),
        .o_f    (f),
        .o_y    (y),
        .o_wb   (wb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_q       <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (fire && wb.q_we) begin
                r_q <= wb.q_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_cmd.data;
        end
        if (fire) begin
            r_out.alu_result <= 16'(f);
            r_out.y_out      <= 16'(y);
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

endmodule

FILE: rtl/core/bsa_regfile.sv
// bsa_regfile: 16-word register file, two registered read ports, one write port
// depends on bsa_pkg; per-entry valid bits make unwritten words read as zero

module bsa_regfile (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rd_en,
    input  bsa_pkg::t_raddr i_addr_a,
    input  bsa_pkg::t_raddr i_addr_b,
    output bsa_pkg::t_word o_data_a,
    output bsa_pkg::t_word o_data_b,
    input  logic           i_we,
    input  bsa_pkg::t_raddr i_waddr,
    input  bsa_pkg::t_word i_wdata
);
    import bsa_pkg::*;

    t_word                mem [RF_DEPTH];
    logic [RF_DEPTH-1:0]  r_vld;
    t_word                r_rd_a;
    t_word                r_rd_b;
    logic                 r_vld_a;
    logic                 r_vld_b;
    logic                 r_hit_a;
    logic                 r_hit_b;
    t_word                r_byp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rd_a <= mem[i_addr_a];
            r_rd_b <= mem[i_addr_b];
            r_byp  <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_vld[i_addr_a];
                r_vld_b <= r_vld[i_addr_b];
                // write in the same cycle as the read: forward the new word
                r_hit_a <= i_we && (i_waddr == i_addr_a);
                r_hit_b <= i_we && (i_waddr == i_addr_b);
            end
        end
    end

    assign o_data_a = r_hit_a ? r_byp : (r_vld_a ? r_rd_a : '0);
    assign o_data_b = r_hit_b ? r_byp : (r_vld_b ? r_rd_b : '0);

endmodule

FILE: rtl/core/bsa_alu.sv
// bsa_alu: operand select, alu function and destination shift/writeback logic
// depends on bsa_pkg; purely combinational

module bsa_alu (
    input  bsa_pkg::t_in_item i_item,
    input  bsa_pkg::t_word    i_a,
    input  bsa_pkg::t_word    i_b,
    input  bsa_pkg::t_word    i_q,
    output bsa_pkg::t_word    o_f,
    output bsa_pkg::t_word    o_y,
    output bsa_pkg::t_wb      o_wb
);
    import bsa_pkg::*;

    t_word      r_op;
    t_word      s_op;
    t_word      f;
    t_word      cin;
    t_word      d;
    logic [2:0] fn;
    logic [2:0] src;

    assign fn  = i_item.opcode[5:3];
    assign src = i_item.opcode[2:0];
    assign cin = {{(DATA_WIDTH-1){1'b0}}, i_item.carry_in};
    assign d   = t_word'(i_item.direct_data);

    always_comb begin
        unique case (src)
            SRC_AQ:  begin r_op = i_a; s_op = i_q; end
            SRC_AB:  begin r_op = i_a; s_op = i_b; end
            SRC_ZQ:  begin r_op = '0;  s_op = i_q; end
            SRC_ZB:  begin r_op = '0;  s_op = i_b; end
            SRC_ZA:  begin r_op = '0;  s_op = i_a; end
            SRC_DA:  begin r_op = d;   s_op = i_a; end
            SRC_DQ:  begin r_op = d;   s_op = i_q; end
            default: begin r_op = d;   s_op = '0;  end
        endcase
    end

    always_comb begin
        unique case (fn)
            FN_ADD:   f = r_op + s_op + cin;
            FN_SUBR:  f = ~r_op + s_op + cin;
            FN_SUBS:  f = r_op + ~s_op + cin;
            FN_OR:    f = r_op | s_op;
            FN_AND:   f = r_op & s_op;
            FN_NOTRS: f = ~r_op & s_op;
            FN_EXOR:  f = r_op ^ s_op;
            default:  f = ~(r_op ^ s_op);
        endcase
    end

    always_comb begin
        o_y          = f;
        o_wb.rf_we   = 1'b1;
        o_wb.rf_wdata = f;
        o_wb.q_we    = 1'b0;
        o_wb.q_wdata = f;
        unique case (i_item.destination)
            DST_QREG: begin
                o_wb.rf_we = 1'b0;
                o_wb.q_we  = 1'b1;
            end
            DST_NOP: begin
                o_wb.rf_we = 1'b0;
            end
            DST_RAMA: begin
                o_y = i_a;
            end
            DST_RAMF: begin
            end
            DST_RAMQD: begin
                // down shift: ones into the register top, zero into q
                o_wb.rf_wdata = {1'b1, f[DATA_WIDTH-1:1]};
                o_wb.q_we     = 1'b1;
                o_wb.q_wdata  = {1'b0, i_q[DATA_WIDTH-1:1]};
            end
            DST_RAMD: begin
                o_wb.rf_wdata = {1'b1, f[DATA_WIDTH-1:1]};
            end
            DST_RAMQU: begin
                o_wb.rf_wdata = {f[DATA_WIDTH-2:0], 1'b0};
                o_wb.q_we     = 1'b1;
                o_wb.q_wdata  = {i_q[DATA_WIDTH-2:0], 1'b0};
            end
            default: begin
                o_wb.rf_wdata = {f[DATA_WIDTH-2:0], 1'b0};
            end
        endcase
    end

    assign o_f = f;

endmodule

FILE: rtl/core/bsa_checker.sv
// bsa_checker: port-level assertions for bit_slice_alu_16bit, attached by bind
// depends on bsa_pkg

module bsa_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bsa_pkg::t_out_item i_out_data
);
    import bsa_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // commands taken but not yet delivered
    always_comb begin
        n_cnt = r_cnt;
        if (in_beat && !out_beat) begin
            n_cnt = r_cnt + 2'd1;
        end else if (out_beat && !in_beat) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("more than two commands in flight");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 2'd0)
        else $error("result beat without a pending command");

    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("command stalled while the result side is ready");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result beat changed");

endmodule

bind bit_slice_alu_16bit bsa_checker u_bsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
